// ===== hdl/b64d_pkg.sv =====
// Shared types, codes and the character classifier of the Base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	localparam logic [7:0] SYM_SKIP = 8'd253;
	localparam logic [7:0] SYM_PAD  = 8'd254;
	localparam logic [7:0] SYM_BAD  = 8'd255;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_OK      = 2'd1,
		KIND_BADCHAR = 2'd2,
		KIND_BADLEN  = 2'd3
	} kind_t;

	// At most one job per accepted character: up to three data bytes and an optional status word.
	typedef struct packed {
		logic [23:0] bytes;
		logic [1:0]  nbytes;
		logic        stat;
		kind_t       kind;
	} job_t;

	function automatic logic [7:0] classify(input logic [7:0] ch);
		logic [7:0] sym;
		begin
			case (ch) inside
				[8'h41:8'h5a]: sym = 8'(ch - 8'h41);
				[8'h61:8'h7a]: sym = 8'(ch - 8'h61 + 8'd26);
				[8'h30:8'h39]: sym = 8'(ch - 8'h30 + 8'd52);
				8'h2b:         sym = 8'd62;
				8'h2f:         sym = 8'd63;
				8'h3d:         sym = SYM_PAD;
				8'h0d, 8'h0a, 8'h20: sym = SYM_SKIP;
				default:       sym = SYM_BAD;
			endcase
			return sym;
		end
	endfunction

endpackage

// ===== hdl/b64d_front.sv =====
// Front end: accepts characters, tracks quartet state and emits one job per productive character.
`timescale 1ns / 1ps

module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       job_valid,
	output job_t       job
);

	logic [23:0] quartet_q;
	logic [1:0]  count_q;
	logic [1:0]  budget_q;
	logic [1:0]  phase_q;
	logic        error_q;

	logic [23:0] quartet_d;
	logic [1:0]  count_d;
	logic [1:0]  budget_d;
	logic [1:0]  phase_d;
	logic        error_d;
	logic [7:0]  sym;
	logic [5:0]  sym6;
	logic [23:0] shifted;

	always_comb begin
		sym       = classify(in_char);
		sym6      = (sym == SYM_PAD) ? 6'd0 : sym[5:0];
		shifted   = {quartet_q[17:0], sym6};
		quartet_d = quartet_q;
		count_d   = count_q;
		budget_d  = budget_q;
		phase_d   = phase_q + 2'd1;
		error_d   = error_q;
		job       = '{bytes: shifted, nbytes: 2'd0, stat: 1'b0, kind: KIND_DATA};

		if (!error_q) begin
			if (sym == SYM_BAD) begin
				error_d = 1'b1;
			end else if (sym != SYM_SKIP) begin
				if (sym == SYM_PAD && budget_q != 2'd0) begin
					budget_d = budget_q - 2'd1;
				end
				if (count_q == 2'd3) begin
					// The pad budget after this symbol decides how many bytes go out.
					job.nbytes = 2'd1 + {1'b0, budget_d > 2'd1} + {1'b0, budget_d > 2'd2};
					quartet_d  = '0;
					count_d    = 2'd0;
				end else begin
					quartet_d = shifted;
					count_d   = count_q + 2'd1;
				end
			end
		end

		if (in_last) begin
			job.stat = 1'b1;
			if (phase_d != 2'd0) begin
				job.kind = KIND_BADLEN;
			end else if (error_d) begin
				job.kind = KIND_BADCHAR;
			end else begin
				job.kind = KIND_OK;
			end
			quartet_d = '0;
			count_d   = 2'd0;
			budget_d  = 2'd3;
			phase_d   = 2'd0;
			error_d   = 1'b0;
		end

		job_valid = accept && (job.nbytes != 2'd0 || job.stat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quartet_q <= '0;
			count_q   <= 2'd0;
			budget_q  <= 2'd3;
			phase_q   <= 2'd0;
			error_q   <= 1'b0;
		end else if (accept) begin
			quartet_q <= quartet_d;
			count_q   <= count_d;
			budget_q  <= budget_d;
			phase_q   <= phase_d;
			error_q   <= error_d;
		end
	end

endmodule

// ===== hdl/b64d_fifo.sv =====
// Short job queue between the front end and the result serializer.
`timescale 1ns / 1ps

module b64d_fifo
	import b64d_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output job_t rd_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/b64d_back.sv =====
// Back end: splits each job into result words and holds the oldest word in an output register.
`timescale 1ns / 1ps

module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       take,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       out_last
);

	job_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	kind_t      okind_q;
	logic       olast_q;

	logic [2:0] total;
	logic       word_last;
	logic       is_data;
	logic       advance;
	logic       cur_done;
	logic [7:0] word_byte;
	kind_t      word_kind;

	always_comb begin
		total     = {1'b0, cur_q.nbytes} + {2'b00, cur_q.stat};
		word_last = ({1'b0, idx_q} == total - 3'd1);
		is_data   = (idx_q < cur_q.nbytes);
		case (idx_q)
			2'd0:    word_byte = cur_q.bytes[23:16];
			2'd1:    word_byte = cur_q.bytes[15:8];
			default: word_byte = cur_q.bytes[7:0];
		endcase
		if (!is_data) begin
			word_byte = 8'd0;
		end
		word_kind = is_data ? KIND_DATA : cur_q.kind;
		advance   = cur_valid_q && (!ovalid_q || pop);
		cur_done  = advance && word_last;
		take      = head_valid && (!cur_valid_q || cur_done);
	end

	assign empty    = !ovalid_q;
	assign out_byte = obyte_q;
	assign out_kind = okind_q;
	assign out_last = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			ovalid_q    <= 1'b0;
		end else begin
			if (take) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 2'd1;
			end
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= head_job;
		end
		if (advance) begin
			obyte_q <= word_byte;
			okind_q <= word_kind;
			olast_q <= word_last;
		end
	end

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// Base64 stream decoder: one encoded character in, decoded bytes and a status word out.
//
// Usage: the input side is a queue write port. A character is taken on a clock edge
// with push high and full low; in_last marks the final character of a message.
// The result side is a queue read port. While empty is low the oldest word sits on
// out_byte, out_kind and out_last, and it leaves on an edge with pop high.
// Each character yields zero to four words: decoded bytes when a quartet completes,
// then a status word (ok, bad character or bad length) when in_last was set.
// out_last marks the final word caused by one character.
// Throughput: one character per cycle while the job queue has room; the serializer sends
// one word per cycle while pop keeps up, so long runs of multi-word characters or stalls
// fill the queue. A job goes through the queue and the current-job register before its
// first word is registered. When pop stays low the output register holds its word, the
// serializer and then the job queue fill, and full rises; no word is lost or repeated.
// Reset clears the queue, the output register and the decoding state of the message.
`timescale 1ns / 1ps

module base64_stream_decoder
	import b64d_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       out_last
);

	logic accept;
	logic job_valid;
	job_t job;
	logic head_valid;
	job_t head_job;
	logic take;

	assign accept = push && !full;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_char  (in_char),
		.in_last  (in_last),
		.job_valid(job_valid),
		.job      (job)
	);

	b64d_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_job  (job),
		.full    (full),
		.rd_en   (take),
		.rd_valid(head_valid),
		.rd_job  (head_job)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_job  (head_job),
		.take      (take),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_kind  (out_kind),
		.out_last  (out_last)
	);

endmodule
